// ----- rtl/core/polar_scan_to_cartesian_core_defines.svh -----
// ----------------------------------------------------------------------------
// polar_scan_to_cartesian_core_defines.svh
// Assertion macros shared by the core RTL. All checks use the clk/rst_n pair
// of the enclosing module and are compiled away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef POLAR_SCAN_TO_CARTESIAN_CORE_DEFINES_SVH
`define POLAR_SCAN_TO_CARTESIAN_CORE_DEFINES_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define PSCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen outside reset
`define PSCC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PSCC_ASSERT(lbl, prop, msg)
`define PSCC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/core/pscc_pkg.sv -----
// ----------------------------------------------------------------------------
// pscc_pkg
// Constants, types and the arctangent table of the polar-to-Cartesian core.
// ----------------------------------------------------------------------------
`default_nettype none

package pscc_pkg;

  // Block configuration
  localparam int CORDIC_STAGES = 16;
  localparam int RANGE_BITS    = 16;
  localparam int ANGLE_BITS    = 16;

  // Fixed-point formats
  localparam int FRAC_BITS   = 16;          // fraction bits of x/y in the chain
  localparam int GAIN_BITS   = 30;          // gain constant is Q30
  localparam logic [GAIN_BITS-1:0] GAIN_Q30 = GAIN_BITS'(652032874);
  localparam int PROD_W      = RANGE_BITS + GAIN_BITS;
  localparam int X0_W        = PROD_W - (GAIN_BITS - FRAC_BITS);
  localparam int XY_W        = X0_W + 2;    // headroom for CORDIC growth and sign
  localparam int Z_W         = 33;          // 2^32 per turn, signed
  localparam int RND_W       = XY_W - FRAC_BITS;
  localparam int OUT_W       = 17;
  localparam int CFG_W       = 16;
  localparam int IN_W        = 16;
  localparam int SAT_LIMIT   = 65535;

  // Arctangent table: atan(2^-i) in 2^32-per-turn units
  localparam int ATAN_DEPTH  = 24;
  localparam int STAGE_IDX_W = $clog2(ATAN_DEPTH);
  localparam logic [31:0] ATAN_LUT [0:ATAN_DEPTH-1] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Configuration register indexes
  localparam logic CFG_ANGLE_START = 1'b0;
  localparam logic CFG_ANGLE_STEP  = 1'b1;

  // Quadrant codes (top two angle bits)
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Control that travels alongside each item in the pipeline
  typedef struct packed {
    logic       valid;
    logic [1:0] quad;
    logic       last;
  } pscc_tag_t;

endpackage

`default_nettype wire

// ----- rtl/core/pscc_if.sv -----
// ----------------------------------------------------------------------------
// pscc_in_if / pscc_out_if
// Valid/ready channels carrying range samples in and Cartesian points out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pscc_in_if import pscc_pkg::*;;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] range_mm;
  logic            last_of_scan;

  modport source (output valid, range_mm, last_of_scan, input ready);
  modport sink   (input valid, range_mm, last_of_scan, output ready);
endinterface

interface pscc_out_if import pscc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] x_mm;
  logic signed [OUT_W-1:0] y_mm;
  logic                    scan_end;

  modport source (output valid, x_mm, y_mm, scan_end, input ready);
  modport sink   (input valid, x_mm, y_mm, scan_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pscc_front.sv -----
// ----------------------------------------------------------------------------
// pscc_front
// Sample angle generation, gain pre-scaling of the range and config regs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polar_scan_to_cartesian_core_defines.svh"

module pscc_front
  import pscc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [IN_W-1:0]         range_mm,
  input  wire logic                    last_of_scan,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata,
  output pscc_tag_t                    tag_o,
  output logic signed [XY_W-1:0]       x_o,
  output logic signed [XY_W-1:0]       y_o,
  output logic signed [Z_W-1:0]        z_o
);

  logic [ANGLE_BITS-1:0] start_r;
  logic [ANGLE_BITS-1:0] step_r;
  logic [ANGLE_BITS-1:0] offset_r;
  logic [ANGLE_BITS-1:0] offset_nxt;
  logic [ANGLE_BITS-1:0] angle;
  logic                  accept;

  pscc_tag_t             tag1_r;
  logic [PROD_W-1:0]     prod_r;
  logic signed [Z_W-1:0] z1_r;

  pscc_tag_t             tag2_r;
  logic [X0_W-1:0]       x0_r;
  logic signed [Z_W-1:0] z2_r;

  assign accept = in_valid && en;
  assign angle  = start_r + offset_r;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      step_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_START: start_r <= cfg_wdata[ANGLE_BITS-1:0];
        CFG_ANGLE_STEP:  step_r  <= cfg_wdata[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Running angle offset, back to zero after the last item of a scan
  assign offset_nxt = last_of_scan ? '0 : offset_r + step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (accept) begin
      offset_r <= offset_nxt;
    end
  end

  // Stage 1: range times gain, angle split into quadrant and residue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else if (en) begin
      tag1_r.valid <= in_valid;
      tag1_r.quad  <= angle[ANGLE_BITS-1 -: 2];
      tag1_r.last  <= last_of_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(range_mm[RANGE_BITS-1:0]) * PROD_W'(GAIN_Q30);
      z1_r   <= $signed(Z_W'({angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}}));
    end
  end

  // Stage 2: round product to Q16
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else if (en) begin
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= X0_W'((prod_r + PROD_W'(1 << (GAIN_BITS - FRAC_BITS - 1)))
                    >> (GAIN_BITS - FRAC_BITS));
      z2_r <= z1_r;
    end
  end

  assign tag_o = tag2_r;
  assign x_o   = $signed({{(XY_W-X0_W){1'b0}}, x0_r});
  assign y_o   = '0;
  assign z_o   = z2_r;

  // Checks
  `PSCC_ASSERT(a_offset_clear, (accept && last_of_scan) |=> (offset_r == '0), "offset not cleared")
  `PSCC_ASSERT(a_offset_step, (accept && !last_of_scan) |=> (offset_r == ($past(offset_r) + $past(step_r))), "offset step wrong")

endmodule

`default_nettype wire

// ----- rtl/core/pscc_cell.sv -----
// ----------------------------------------------------------------------------
// pscc_cell
// One CORDIC rotation step: micro-rotate by +/-atan(2^-i), register result.
// ----------------------------------------------------------------------------
`default_nettype none

module pscc_cell
  import pscc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic [STAGE_IDX_W-1:0]  stage_idx,
  input  pscc_tag_t                    tag_i,
  input  wire logic signed [XY_W-1:0]  x_i,
  input  wire logic signed [XY_W-1:0]  y_i,
  input  wire logic signed [Z_W-1:0]   z_i,
  output pscc_tag_t                    tag_o,
  output logic signed [XY_W-1:0]       x_o,
  output logic signed [XY_W-1:0]       y_o,
  output logic signed [Z_W-1:0]        z_o
);

  pscc_tag_t             tag_r;
  logic signed [XY_W-1:0] x_r, x_nxt;
  logic signed [XY_W-1:0] y_r, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  da;

  // Shifted terms floor toward minus infinity
  assign dx = y_i >>> stage_idx;
  assign dy = x_i >>> stage_idx;
  assign da = $signed({{(Z_W-32){1'b0}}, ATAN_LUT[stage_idx]});

  // Rotate toward zero residual angle
  always_comb begin
    if (!z_i[Z_W-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - da;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + da;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign tag_o = tag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

`default_nettype wire

// ----- rtl/core/pscc_out.sv -----
// ----------------------------------------------------------------------------
// pscc_out
// Quadrant fold, rounding to mm with saturation, output register and skid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polar_scan_to_cartesian_core_defines.svh"

module pscc_out
  import pscc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  output logic                         en,
  input  pscc_tag_t                    tag_i,
  input  wire logic signed [XY_W-1:0]  c_i,
  input  wire logic signed [XY_W-1:0]  s_i,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      x_mm,
  output logic signed [OUT_W-1:0]      y_mm,
  output logic                         scan_end
);

  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(SAT_LIMIT);
  localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI;

  pscc_tag_t              sw_tag_r;
  logic signed [XY_W-1:0] sw_x_r, sw_y_r;
  logic signed [XY_W-1:0] fx, fy;

  logic signed [RND_W-1:0] rx, ry;
  logic signed [OUT_W-1:0] mx, my;

  logic                    out_valid_r, skid_valid_r;
  logic signed [OUT_W-1:0] out_x_r, out_y_r, skid_x_r, skid_y_r;
  logic                    out_last_r, skid_last_r;
  logic                    out_free;

  // Pipeline moves whenever the skid slot is empty
  assign en       = !skid_valid_r;
  assign out_free = !out_valid_r || out_ready;

  // Fold the quadrant back with exact swaps and negations
  always_comb begin
    case (tag_i.quad)
      QUAD_0:  begin fx = c_i;  fy = s_i;  end
      QUAD_1:  begin fx = -s_i; fy = c_i;  end
      QUAD_2:  begin fx = -c_i; fy = -s_i; end
      QUAD_3:  begin fx = s_i;  fy = -c_i; end
      default: begin fx = c_i;  fy = s_i;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_tag_r <= '0;
    end else if (en) begin
      sw_tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sw_x_r <= fx;
      sw_y_r <= fy;
    end
  end

  // Round half up to whole mm, then clamp
  assign rx = RND_W'((sw_x_r + XY_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
  assign ry = RND_W'((sw_y_r + XY_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);

  always_comb begin
    if (rx > SAT_HI)      mx = OUT_W'(SAT_HI);
    else if (rx < SAT_LO) mx = OUT_W'(SAT_LO);
    else                  mx = rx[OUT_W-1:0];
    if (ry > SAT_HI)      my = OUT_W'(SAT_HI);
    else if (ry < SAT_LO) my = OUT_W'(SAT_LO);
    else                  my = ry[OUT_W-1:0];
  end

  // Output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (sw_tag_r.valid) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_x_r    <= skid_x_r;
        out_y_r    <= skid_y_r;
        out_last_r <= skid_last_r;
      end
    end else if (sw_tag_r.valid) begin
      if (out_free) begin
        out_x_r    <= mx;
        out_y_r    <= my;
        out_last_r <= sw_tag_r.last;
      end else begin
        skid_x_r    <= mx;
        skid_y_r    <= my;
        skid_last_r <= sw_tag_r.last;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign x_mm      = out_x_r;
  assign y_mm      = out_y_r;
  assign scan_end  = out_last_r;

  // Checks
  `PSCC_ASSERT_NEVER(a_skid_alone, skid_valid_r && !out_valid_r, "skid holds item with empty output")
  `PSCC_ASSERT(a_skid_fill, (sw_tag_r.valid && en && out_valid_r && !out_ready) |=> skid_valid_r, "stalled item dropped")
  `PSCC_ASSERT(a_skid_hold, (skid_valid_r && !out_ready) |=> (skid_valid_r && $stable(skid_x_r) && $stable(skid_y_r)), "skid item lost")

endmodule

`default_nettype wire

// ----- rtl/core/polar_scan_to_cartesian_core.sv -----
// ----------------------------------------------------------------------------
// polar_scan_to_cartesian_core
// Converts range samples of a lidar scan into Cartesian points with a
// pipelined rotation-mode CORDIC, one cell per micro-rotation.
//
//   channel   dir  handshake      payload
//   in_if     in   valid/ready    range_mm[15:0], last_of_scan
//   out_if    out  valid/ready    x_mm[16:0], y_mm[16:0], scan_end
//   cfg_*     in   write enable   cfg_index (0 start, 1 step), cfg_wdata[15:0]
//
// One item per clock sustained while out_if takes results; an item passes
// two front stages, one cell per stage, quadrant fold, output register.
// Synchronous active-low reset clears all valid flags and config registers.
// in_if.ready is low only while the skid slot holds an item; the whole
// pipeline then holds in place until out_if takes a result.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_scan_to_cartesian_core
  import pscc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  pscc_in_if.sink                in_if,
  pscc_out_if.source             out_if,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  logic en;

  pscc_tag_t              tag_c [0:CORDIC_STAGES];
  logic signed [XY_W-1:0] x_c   [0:CORDIC_STAGES];
  logic signed [XY_W-1:0] y_c   [0:CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_c   [0:CORDIC_STAGES];

  assign in_if.ready = en;

  // Angle generation and gain pre-scale
  pscc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_if.valid),
    .range_mm     (in_if.range_mm),
    .last_of_scan (in_if.last_of_scan),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .tag_o        (tag_c[0]),
    .x_o          (x_c[0]),
    .y_o          (y_c[0]),
    .z_o          (z_c[0])
  );

  // CORDIC cell chain
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    pscc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .stage_idx (STAGE_IDX_W'(k)),
      .tag_i     (tag_c[k]),
      .x_i       (x_c[k]),
      .y_i       (y_c[k]),
      .z_i       (z_c[k]),
      .tag_o     (tag_c[k+1]),
      .x_o       (x_c[k+1]),
      .y_o       (y_c[k+1]),
      .z_o       (z_c[k+1])
    );
  end

  // Quadrant fold, rounding and output buffering
  pscc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .tag_i     (tag_c[CORDIC_STAGES]),
    .c_i       (x_c[CORDIC_STAGES]),
    .s_i       (y_c[CORDIC_STAGES]),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .x_mm      (out_if.x_mm),
    .y_mm      (out_if.y_mm),
    .scan_end  (out_if.scan_end)
  );

endmodule

`default_nettype wire
